// ----- hdl/gwt_pkg.sv -----
// Shared types, character codes and limits for the G-code word tokenizer.
`timescale 1ns / 1ps

package gwt_pkg;

  localparam int MAX_DIGITS  = 9;
  localparam int ACC_W       = 30;
  localparam int VAL_W       = ACC_W + 4;
  localparam int FRAC_W      = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // smaller of 10^MAX_DIGITS-1 and the accumulator's full range
  function automatic logic [63:0] digit_cap_f(input int ndig);
    logic [63:0] cap;
    logic [63:0] lim;
    cap = 64'd1;
    lim = (64'd1 << ACC_W) - 64'd1;
    for (int k = 0; k < ndig; k++) begin
      if (cap <= lim) begin
        cap = cap * 64'd10;
      end
    end
    cap = cap - 64'd1;
    if (cap > lim) begin
      cap = lim;
    end
    return cap;
  endfunction

  localparam logic [63:0]      DIGIT_CAP64 = digit_cap_f(MAX_DIGITS);
  localparam logic [VAL_W-1:0] DIGIT_CAP   = DIGIT_CAP64[VAL_W-1:0];
  localparam logic [ACC_W-1:0] STOP_CODE   = ACC_W'(84);
  localparam logic [FRAC_W-1:0] FRAC_MAX   = FRAC_W'(9);

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_M  = 8'h4D;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_STOP = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         letter;
    logic [ACC_W-1:0]   digits;
    logic [FRAC_W-1:0]  decimals;
    logic               negative;
    logic               last;
  } result_t;

  // up to two results per character, slot 0 always used first
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } res_pair_t;

  function automatic logic is_address_f(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= CHAR_LO_A && c <= CHAR_LO_Z) ? (c - CASE_BIT) : c;
    case (u) inside
      8'h47, 8'h4D, 8'h54, 8'h46, 8'h53, 8'h58,
      8'h59, 8'h5A, 8'h41, 8'h42, 8'h43, 8'h45: return 1'b1;
      default:                                   return 1'b0;
    endcase
  endfunction

endpackage

// ----- hdl/gwt_front.sv -----
// Front end: character classification and word/line scanner state.
`timescale 1ns / 1ps

module gwt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          char_i,
  output gwt_pkg::res_pair_t  out_o
);

  logic                         in_word_q, in_word_d;
  logic [7:0]                   letter_q, letter_d;
  logic [gwt_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [gwt_pkg::FRAC_W-1:0]   frac_q, frac_d;
  logic                         point_q, point_d;
  logic                         minus_q, minus_d;
  logic                         lhw_q, lhw_d;
  logic                         skip_q, skip_d;

  logic                         is_digit;
  logic                         is_num;
  logic [gwt_pkg::VAL_W-1:0]    acc_ext;
  logic [gwt_pkg::VAL_W-1:0]    acc_next;

  assign is_digit = (char_i >= gwt_pkg::CHAR_ZERO) && (char_i <= gwt_pkg::CHAR_NINE);
  assign is_num   = is_digit || (char_i == gwt_pkg::CHAR_SPACE) ||
                    (char_i == gwt_pkg::CHAR_POINT) || (char_i == gwt_pkg::CHAR_MINUS);
  // acc*10 + digit; digit value is the low nibble of '0'..'9'
  assign acc_ext  = {4'b0, acc_q};
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) +
                    {{(gwt_pkg::VAL_W-4){1'b0}}, char_i[3:0]};

  always_comb begin
    logic stop;
    gwt_pkg::result_t word_res;
    gwt_pkg::result_t eol_res;

    in_word_d = in_word_q;
    letter_d  = letter_q;
    acc_d     = acc_q;
    frac_d    = frac_q;
    point_d   = point_q;
    minus_d   = minus_q;
    lhw_d     = lhw_q;
    skip_d    = skip_q;
    out_o     = '0;
    stop      = 1'b0;

    word_res          = '0;
    word_res.kind     = gwt_pkg::KIND_WORD;
    word_res.letter   = letter_q;
    word_res.digits   = acc_q;
    word_res.decimals = frac_q;
    word_res.negative = minus_q;
    eol_res           = '0;
    eol_res.kind      = gwt_pkg::KIND_EOL;

    if (valid_i) begin
      if (skip_q) begin
        if (char_i == gwt_pkg::CHAR_LF) begin
          skip_d = 1'b0;
          lhw_d  = 1'b0;
        end
      end else if (in_word_q && is_num) begin
        if (is_digit) begin
          acc_d = (acc_next > gwt_pkg::DIGIT_CAP) ? gwt_pkg::DIGIT_CAP[gwt_pkg::ACC_W-1:0]
                                                  : acc_next[gwt_pkg::ACC_W-1:0];
          if (point_q && (frac_q < gwt_pkg::FRAC_MAX)) begin
            frac_d = frac_q + 1'b1;
          end
        end else if (char_i == gwt_pkg::CHAR_POINT) begin
          point_d = 1'b1;
        end else if (char_i == gwt_pkg::CHAR_MINUS) begin
          minus_d = 1'b1;
        end
      end else begin
        // a closing character ends the word, then, unless the word was a stop, is scanned on its own
        if (in_word_q) begin
          in_word_d     = 1'b0;
          out_o.push0   = 1'b1;
          out_o.res0    = word_res;
          if (letter_q == gwt_pkg::CHAR_UP_M && acc_q == gwt_pkg::STOP_CODE) begin
            stop             = 1'b1;
            out_o.res0.kind  = gwt_pkg::KIND_STOP;
            lhw_d            = 1'b0;
            skip_d           = (char_i != gwt_pkg::CHAR_LF);
          end else begin
            lhw_d = 1'b1;
          end
        end
        if (!stop) begin
          if (gwt_pkg::is_address_f(char_i)) begin
            in_word_d = 1'b1;
            letter_d  = char_i;
            acc_d     = '0;
            frac_d    = '0;
            point_d   = 1'b0;
            minus_d   = 1'b0;
          end else if (char_i == gwt_pkg::CHAR_SEMI || char_i == gwt_pkg::CHAR_LF) begin
            if (lhw_d) begin
              if (out_o.push0) begin
                out_o.push1 = 1'b1;
                out_o.res1  = eol_res;
              end else begin
                out_o.push0 = 1'b1;
                out_o.res0  = eol_res;
              end
            end
            lhw_d = 1'b0;
            if (char_i == gwt_pkg::CHAR_SEMI) begin
              skip_d = 1'b1;
            end
          end
        end
        if (out_o.push1) begin
          out_o.res1.last = 1'b1;
        end else if (out_o.push0) begin
          out_o.res0.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      letter_q  <= '0;
      acc_q     <= '0;
      frac_q    <= '0;
      point_q   <= 1'b0;
      minus_q   <= 1'b0;
      lhw_q     <= 1'b0;
      skip_q    <= 1'b0;
    end else begin
      in_word_q <= in_word_d;
      letter_q  <= letter_d;
      acc_q     <= acc_d;
      frac_q    <= frac_d;
      point_q   <= point_d;
      minus_q   <= minus_d;
      lhw_q     <= lhw_d;
      skip_q    <= skip_d;
    end
  end

endmodule

// ----- hdl/gwt_queue.sv -----
// Result queue: up to two writes and one read per cycle, head shown on the output.
`timescale 1ns / 1ps

module gwt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gwt_pkg::res_pair_t  in_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output gwt_pkg::result_t    head_o
);

  gwt_pkg::result_t            mem_q [gwt_pkg::QUEUE_DEPTH];
  logic [gwt_pkg::QPTR_W-1:0]  wr_q, wr_d;
  logic [gwt_pkg::QPTR_W-1:0]  rd_q, rd_d;
  logic [gwt_pkg::QCNT_W-1:0]  cnt_q, cnt_d;
  logic [gwt_pkg::QPTR_W-1:0]  wr_next;
  logic                        do_pop;
  logic [gwt_pkg::QCNT_W-1:0]  n_push;

  assign wr_next = wr_q + 1'b1;
  assign do_pop  = pop_i && (cnt_q != '0);
  assign n_push  = gwt_pkg::QCNT_W'(in_i.push0) + gwt_pkg::QCNT_W'(in_i.push1);
  assign wr_d    = wr_q + n_push[gwt_pkg::QPTR_W-1:0];
  assign rd_d    = do_pop ? rd_q + 1'b1 : rd_q;
  assign cnt_d   = cnt_q + n_push - gwt_pkg::QCNT_W'(do_pop);

  // keep room for a two-result character
  assign full_o  = cnt_q > gwt_pkg::QCNT_W'(gwt_pkg::QUEUE_DEPTH - 2);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.push0) begin
      mem_q[wr_q] <= in_i.res0;
    end
    if (in_i.push1) begin
      mem_q[wr_next] <= in_i.res1;
    end
  end

endmodule

// ----- hdl/gcode_word_tokenizer_top.sv -----
// G-code word tokenizer: top level with scanner front end and result queue.
// A result is written into the result queue at the clock edge that accepts the
// character that causes it. Throughput: one character per cycle while full is
// low; full rises while the 4-entry result queue has fewer than two free entries.
// Reset (rst_ni, asynchronous): scanner state cleared, queue emptied.
`timescale 1ns / 1ps

module gcode_word_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  letter_o,
  output logic [29:0] digits_o,
  output logic [3:0]  decimals_o,
  output logic        negative_o,
  output logic        last_o
);

  logic               accept;
  gwt_pkg::res_pair_t pair;
  gwt_pkg::result_t   head;

  assign accept = push && !full;

  gwt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .char_i  (char_in_i),
    .out_o   (pair)
  );

  gwt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pair),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  assign kind_o     = head.kind;
  assign letter_o   = head.letter;
  assign digits_o   = head.digits;
  assign decimals_o = head.decimals;
  assign negative_o = head.negative;
  assign last_o     = head.last;

endmodule

// ----- bench/gcode_word_tokenizer_top_tb.sv -----
// Testbench for gcode_word_tokenizer_top: random G-code text in, scanned words checked out.
`timescale 1ns / 1ps

module gcode_word_tokenizer_top_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_CHARS    = 455;
  localparam int SHOWN_ERRORS   = 10;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        push     = 1'b0;
  logic        full;
  logic [7:0]  char_in  = 8'h00;
  logic        empty;
  logic        pop      = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  letter;
  logic [29:0] digits;
  logic [3:0]  decimals;
  logic        negative;
  logic        is_last;

  gcode_word_tokenizer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .char_in_i  (char_in),
    .empty      (empty),
    .pop        (pop),
    .kind_o     (kind),
    .letter_o   (letter),
    .digits_o   (digits),
    .decimals_o (decimals),
    .negative_o (negative),
    .last_o     (is_last)
  );

  always #1 clk_i = ~clk_i;

  // text waiting to be sent, and the tokens the scanner should produce
  logic [7:0]        pending_text[$];
  gwt_pkg::result_t  expected_tokens[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int chars_taken    = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  // scanner state as predicted
  logic                      sc_in_word    = 1'b0;
  logic [7:0]                sc_letter     = 8'h00;
  logic [gwt_pkg::ACC_W-1:0] sc_acc        = '0;
  logic [3:0]                sc_frac       = '0;
  logic                      sc_point      = 1'b0;
  logic                      sc_minus      = 1'b0;
  logic                      sc_line_words = 1'b0;
  logic                      sc_skipping   = 1'b0;

  function automatic logic opens_word(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= gwt_pkg::CHAR_LO_A && c <= gwt_pkg::CHAR_LO_Z) ? (c - gwt_pkg::CASE_BIT) : c;
    case (u)
      "G", "M", "T", "F", "S", "X", "Y", "Z", "A", "B", "C", "E": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic scan_char(input logic [7:0] c);
    gwt_pkg::result_t          toks[2];
    int                        n;
    logic [gwt_pkg::VAL_W-1:0] grown;
    n = 0;
    if (sc_skipping) begin
      if (c == gwt_pkg::CHAR_LF) begin
        sc_skipping   = 1'b0;
        sc_line_words = 1'b0;
      end
      return;
    end
    if (sc_in_word) begin
      if (c >= gwt_pkg::CHAR_ZERO && c <= gwt_pkg::CHAR_NINE) begin
        grown  = gwt_pkg::VAL_W'(sc_acc) * gwt_pkg::VAL_W'(10) +
                 gwt_pkg::VAL_W'(c - gwt_pkg::CHAR_ZERO);
        sc_acc = (grown > gwt_pkg::DIGIT_CAP) ? gwt_pkg::DIGIT_CAP[gwt_pkg::ACC_W-1:0]
                                              : grown[gwt_pkg::ACC_W-1:0];
        if (sc_point && sc_frac < gwt_pkg::FRAC_MAX) sc_frac++;
        return;
      end
      if (c == gwt_pkg::CHAR_SPACE) return;
      if (c == gwt_pkg::CHAR_POINT) begin
        sc_point = 1'b1;
        return;
      end
      if (c == gwt_pkg::CHAR_MINUS) begin
        sc_minus = 1'b1;
        return;
      end
      sc_in_word = 1'b0;
      // M84 stops: rest of line dropped, no end-of-line token
      if (sc_letter == gwt_pkg::CHAR_UP_M && sc_acc == gwt_pkg::STOP_CODE) begin
        expected_tokens.push_back('{kind: gwt_pkg::KIND_STOP, letter: sc_letter,
                                    digits: sc_acc, decimals: sc_frac,
                                    negative: sc_minus, last: 1'b1});
        sc_line_words = 1'b0;
        sc_skipping   = (c != gwt_pkg::CHAR_LF);
        return;
      end
      toks[0] = '{kind: gwt_pkg::KIND_WORD, letter: sc_letter, digits: sc_acc,
                  decimals: sc_frac, negative: sc_minus, last: 1'b0};
      sc_line_words = 1'b1;
      n = 1;
    end
    if (opens_word(c)) begin
      sc_in_word = 1'b1;
      sc_letter  = c;
      sc_acc     = '0;
      sc_frac    = '0;
      sc_point   = 1'b0;
      sc_minus   = 1'b0;
    end else if (c == gwt_pkg::CHAR_SEMI || c == gwt_pkg::CHAR_LF) begin
      if (sc_line_words) begin
        toks[n] = '{kind: gwt_pkg::KIND_EOL, letter: 8'h00, digits: '0,
                    decimals: '0, negative: 1'b0, last: 1'b0};
        n++;
        sc_line_words = 1'b0;
      end
      if (c == gwt_pkg::CHAR_SEMI) sc_skipping = 1'b1;
    end
    if (n > 0) toks[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(toks[i]);
  endtask

  // sender: accepted characters go through the predictor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push    <= 1'b0;
      char_in <= 8'h00;
    end else begin
      if (push && !full) begin
        scan_char(char_in);
        chars_taken++;
      end
      if (!push || !full) begin
        if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push    <= 1'b1;
          char_in <= pending_text.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each popped token against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    gwt_pkg::result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("%0t: unexpected token kind=%0d letter=%h digits=%0d dec=%0d neg=%b last=%b",
                     $realtime, kind, letter, digits, decimals, negative, is_last);
        end else begin
          want = expected_tokens.pop_front();
          if (kind !== want.kind || letter !== want.letter || digits !== want.digits ||
              decimals !== want.decimals || negative !== want.negative ||
              is_last !== want.last) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
              $display(
                "%0t: token mismatch: expected kind=%0d letter=%h digits=%0d dec=%0d neg=%b last=%b",
                $realtime, want.kind, want.letter, want.digits, want.decimals,
                want.negative, want.last);
              $display(
                "%0t:                 got kind=%0d letter=%h digits=%0d dec=%0d neg=%b last=%b",
                $realtime, kind, letter, digits, decimals, negative, is_last);
            end
          end
        end
      end
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: ends a run that stops moving
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_text.push_back(s[i]);
  endtask

  task automatic add_noise(input int count);
    for (int i = 0; i < count; i++) pending_text.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_number();
    int nd;
    int point_at;
    if ($urandom_range(99) < 8) nd = $urandom_range(10, 13);
    else nd = $urandom_range(0, 4);
    point_at = ($urandom_range(99) < 40) ? $urandom_range(0, nd) : -1;
    if ($urandom_range(99) < 20) pending_text.push_back(gwt_pkg::CHAR_MINUS);
    if ($urandom_range(99) < 10) pending_text.push_back(gwt_pkg::CHAR_SPACE);
    for (int i = 0; i < nd; i++) begin
      if (i == point_at) pending_text.push_back(gwt_pkg::CHAR_POINT);
      pending_text.push_back(gwt_pkg::CHAR_ZERO + 8'($urandom_range(9)));
      case ($urandom_range(99))
        0, 1, 2:       pending_text.push_back(gwt_pkg::CHAR_MINUS);
        3, 4, 5:       pending_text.push_back(gwt_pkg::CHAR_POINT);
        6, 7, 8, 9, 10: pending_text.push_back(gwt_pkg::CHAR_SPACE);
        default: ;
      endcase
    end
    if (point_at == nd) pending_text.push_back(gwt_pkg::CHAR_POINT);
  endtask

  task automatic add_word();
    string      addr_set;
    logic [7:0] c;
    addr_set = "GMTFSXYZABCE";
    if ($urandom_range(99) < 6) begin
      case ($urandom_range(5))
        0: add_text("M84");
        1: add_text("M8.4");
        2: add_text("M-84");
        3: add_text("m84");
        4: add_text("M084");
        default: add_text("M 84");
      endcase
    end else begin
      c = addr_set[$urandom_range(11)];
      if ($urandom_range(99) < 30) c = c | gwt_pkg::CASE_BIT;
      pending_text.push_back(c);
      add_number();
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: pending_text.push_back(gwt_pkg::CHAR_SPACE);
      5:             add_noise(1);
      default: ;
    endcase
  endtask

  task automatic add_line();
    int         pick;
    int         nw;
    logic [7:0] b;
    nw = $urandom_range(0, 4);
    for (int i = 0; i < nw; i++) add_word();
    pick = $urandom_range(99);
    if (pick < 20) begin
      pending_text.push_back(gwt_pkg::CHAR_SEMI);
      // comment body: any byte but newline
      for (int i = $urandom_range(8); i > 0; i--) begin
        b = 8'($urandom_range(255));
        if (b == gwt_pkg::CHAR_LF) b = 8'h00;
        pending_text.push_back(b);
      end
    end else if (pick < 30) begin
      add_noise($urandom_range(1, 3));
    end
    pending_text.push_back(gwt_pkg::CHAR_LF);
  endtask

  initial begin
    int queued;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk_i);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      queued = 0;
      if (ph == 0) begin
        // byte extremes, comment on an empty line, stop closed by newline,
        // signed saturating word closed by an unknown byte, empty number,
        // stop closed by a letter with the line skipped
        pending_text.push_back(8'h00);
        pending_text.push_back(8'hFF);
        add_text(";\n");
        add_text("M84\n");
        add_text("x-.1234567890.?g\n");
        add_text("M84y\n");
        queued = pending_text.size();
      end
      while (queued < PHASE_CHARS) begin
        queued -= pending_text.size();
        if ($urandom_range(99) < 10) add_noise($urandom_range(1, 6));
        else add_line();
        queued += pending_text.size();
      end
      if (ph == 0) begin
        // long receiver hold-off while text keeps coming
        while (chars_taken < 100) @(negedge clk_i);
        hold_requests++;
      end
      while (pending_text.size() != 0 || push || expected_tokens.size() != 0)
        @(negedge clk_i);
    end
    recv_stall_pct = 0;
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
